>>> rtl/ethernet_ip_l4_header_parser_defines.svh
// Assertion macros for the header parser checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ETHERNET_IP_L4_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_IP_L4_HEADER_PARSER_DEFINES_SVH

// Checked only while out of reset.
`define ELP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("elp: assertion failed");

// Checked at every edge, reset included.
`define ELP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("elp: reset-time assertion failed");

`endif

>>> rtl/elp_pkg.sv
// Shared constants, codes and types of the Ethernet/IP/L4 header parser.
// No dependencies.
package elp_pkg;

  localparam int MAX_FRAME_DEFAULT = 2048;
  localparam int ICMP_HDR_DEFAULT  = 8;

  localparam int OFS_W = 12;

  // Header sizes in bytes
  localparam int ETH_HDR = 14;
  localparam int IP4_MIN = 20;
  localparam int IP6_HDR = 40;
  localparam int TCP_MIN = 20;
  localparam int UDP_HDR = 8;

  // Frame positions of captured bytes, TCP data-offset position and minimum IHL in words
  localparam int IDX_TYPE_HI  = 12;
  localparam int IDX_TYPE_LO  = 13;
  localparam int IDX_IHL      = 14;
  localparam int IDX_V6_NEXT  = 20;
  localparam int IDX_V4_PROTO = 23;
  localparam int TCP_DOFF_POS = 12;
  localparam int IHL_MIN_WORDS = 5;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [3:0]  IHL_MASK   = 4'hF;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RUNT     = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    L3_NONE   = 2'd0,
    L3_V4_OK  = 2'd1,
    L3_V4_BAD = 2'd2,
    L3_V6     = 2'd3
  } l3_kind_e;

  typedef enum logic [1:0] {
    L4_NONE = 2'd0,
    L4_TCP  = 2'd1,
    L4_UDP  = 2'd2,
    L4_ICMP = 2'd3
  } l4_kind_e;

  // Header fields captured over one frame
  typedef struct packed {
    logic        too_long;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [7:0]  proto_byte;
    logic [3:0]  tcp_words;
  } hdr_t;

endpackage

>>> rtl/elp_if.sv
// Valid/ready channel interfaces of the header parser: frame bytes in,
// per-frame results out. Depends on nothing.
interface elp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface elp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] ether_type;
  logic [1:0]  l3_kind;
  logic [7:0]  ip_protocol;
  logic [1:0]  l4_kind;
  logic [11:0] l4_offset;
  logic        payload_present;
  logic [11:0] payload_offset;
  logic [11:0] payload_length;

  modport source (output valid, status, ether_type, l3_kind, ip_protocol, l4_kind,
                  l4_offset, payload_present, payload_offset, payload_length,
                  input ready);
  modport sink   (input valid, status, ether_type, l3_kind, ip_protocol, l4_kind,
                  l4_offset, payload_present, payload_offset, payload_length,
                  output ready);
endinterface

>>> rtl/elp_front.sv
// Byte-side front end: counts frame bytes and captures header fields.
// Depends on elp_pkg; pushes one summary per frame into the queue.
module elp_front #(
  parameter int MAX_FRAME = elp_pkg::MAX_FRAME_DEFAULT,
  localparam int CW = $clog2(MAX_FRAME + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output logic          push_o,
  output logic [CW-1:0] len_o,
  output elp_pkg::hdr_t hdr_o
);

  logic [CW-1:0] cnt_q, cnt_d, cnt_nxt;
  elp_pkg::hdr_t hdr_q, hdr_d, hdr_nxt;
  logic          at_max;
  logic [CW-1:0] v4_doff_idx;

  assign at_max      = (cnt_q == CW'(MAX_FRAME));
  assign v4_doff_idx = CW'(elp_pkg::ETH_HDR + elp_pkg::TCP_DOFF_POS)
                     + CW'({hdr_q.header_words, 2'b00});

  always_comb begin
    cnt_nxt = cnt_q;
    hdr_nxt = hdr_q;
    if (at_max) begin
      hdr_nxt.too_long = 1'b1;
    end else begin
      cnt_nxt = cnt_q + CW'(1);
      if (cnt_q == CW'(elp_pkg::IDX_TYPE_HI) || cnt_q == CW'(elp_pkg::IDX_TYPE_LO)) begin
        hdr_nxt.ether_type = {hdr_q.ether_type[7:0], byte_i};
      end
      // EtherType is complete from the IHL byte on, so the held value is used
      if (hdr_q.ether_type == elp_pkg::ETYPE_IPV4) begin
        if (cnt_q == CW'(elp_pkg::IDX_IHL)) begin
          hdr_nxt.header_words = byte_i[3:0] & elp_pkg::IHL_MASK;
        end
        if (cnt_q == CW'(elp_pkg::IDX_V4_PROTO)) begin
          hdr_nxt.proto_byte = byte_i;
        end
        if (hdr_q.header_words >= 4'(elp_pkg::IHL_MIN_WORDS) && cnt_q == v4_doff_idx) begin
          hdr_nxt.tcp_words = byte_i[7:4];
        end
      end else if (hdr_q.ether_type == elp_pkg::ETYPE_IPV6) begin
        if (cnt_q == CW'(elp_pkg::IDX_V6_NEXT)) begin
          hdr_nxt.proto_byte = byte_i;
        end
        if (cnt_q == CW'(elp_pkg::ETH_HDR + elp_pkg::IP6_HDR + elp_pkg::TCP_DOFF_POS)) begin
          hdr_nxt.tcp_words = byte_i[7:4];
        end
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    hdr_d  = hdr_q;
    push_o = 1'b0;
    if (beat_i) begin
      if (last_i) begin
        // hand the frame off and start clean
        push_o = 1'b1;
        cnt_d  = '0;
        hdr_d  = '0;
      end else begin
        cnt_d = cnt_nxt;
        hdr_d = hdr_nxt;
      end
    end
  end

  assign len_o = cnt_nxt;
  assign hdr_o = hdr_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hdr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

>>> rtl/elp_queue.sv
// Two-entry queue between the byte front end and the result back end.
// No dependencies.
module elp_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW + 1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
    end
  end

endmodule

>>> rtl/elp_back.sv
// Result back end: classifies layer 3, then locates layer 4 and payload,
// in two registered stages. Depends on elp_pkg and elp_result_if.
module elp_back #(
  parameter int MAX_FRAME      = elp_pkg::MAX_FRAME_DEFAULT,
  parameter int ICMP_HDR_BYTES = elp_pkg::ICMP_HDR_DEFAULT,
  localparam int CW = $clog2(MAX_FRAME + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [CW-1:0] len_i,
  input  elp_pkg::hdr_t hdr_i,
  output logic          pop_o,
  elp_result_if.source  result_o
);

  typedef struct packed {
    elp_pkg::status_e  status;
    logic [15:0]       ether_type;
    elp_pkg::l3_kind_e l3_kind;
    logic [7:0]        proto;
    logic              l4_en;
    logic [CW-1:0]     l4_off;
    logic [CW-1:0]     l4_len;
    logic [3:0]        tcp_words;
  } stage_t;

  stage_t a_d, a_q;
  logic   a_v_q, out_v_q;
  logic   out_adv, a_adv;

  // layer-3 classification
  logic [5:0]    ihl;
  logic [CW-1:0] v4_off, off_sel;
  logic          is_v4, is_v6, ihl_bad;

  assign ihl     = {hdr_i.header_words, 2'b00};
  assign v4_off  = CW'(elp_pkg::ETH_HDR) + CW'(ihl);
  assign ihl_bad = (ihl < 6'(elp_pkg::IP4_MIN)) || (v4_off > len_i);
  assign is_v4   = (hdr_i.ether_type == elp_pkg::ETYPE_IPV4);
  assign is_v6   = (hdr_i.ether_type == elp_pkg::ETYPE_IPV6);
  assign off_sel = is_v4 ? v4_off : CW'(elp_pkg::ETH_HDR + elp_pkg::IP6_HDR);

  always_comb begin
    a_d            = '0;
    a_d.status     = elp_pkg::ST_OK;
    a_d.l3_kind    = elp_pkg::L3_NONE;
    a_d.l4_off     = off_sel;
    a_d.l4_len     = len_i - off_sel;
    a_d.tcp_words  = hdr_i.tcp_words;
    if (hdr_i.too_long) begin
      a_d.status = elp_pkg::ST_OVERSIZE;
    end else if (len_i < CW'(elp_pkg::ETH_HDR)) begin
      a_d.status = elp_pkg::ST_RUNT;
    end else begin
      a_d.ether_type = hdr_i.ether_type;
      if (is_v4) begin
        if (len_i < CW'(elp_pkg::ETH_HDR + elp_pkg::IP4_MIN)) begin
          a_d.l3_kind = elp_pkg::L3_V4_BAD;
        end else begin
          a_d.proto = hdr_i.proto_byte;
          if (ihl_bad) begin
            a_d.l3_kind = elp_pkg::L3_V4_BAD;
          end else begin
            a_d.l3_kind = elp_pkg::L3_V4_OK;
            a_d.l4_en   = 1'b1;
          end
        end
      end else if (is_v6) begin
        if (len_i >= CW'(elp_pkg::ETH_HDR + elp_pkg::IP6_HDR)) begin
          a_d.l3_kind = elp_pkg::L3_V6;
          a_d.proto   = hdr_i.proto_byte;
          a_d.l4_en   = 1'b1;
        end
      end
    end
  end

  // layer-4 and payload location
  logic [5:0]        tcp_h;
  elp_pkg::l4_kind_e l4_kind;
  logic              pay_present;
  logic [CW-1:0]     pay_off, pay_len;

  assign tcp_h = {a_q.tcp_words, 2'b00};

  always_comb begin
    l4_kind     = elp_pkg::L4_NONE;
    pay_present = 1'b0;
    pay_off     = '0;
    pay_len     = '0;
    if (a_q.l4_en) begin
      case (a_q.proto)
        elp_pkg::PROTO_TCP: begin
          if (a_q.l4_len >= CW'(elp_pkg::TCP_MIN)) begin
            l4_kind = elp_pkg::L4_TCP;
            if (tcp_h >= 6'(elp_pkg::TCP_MIN) && CW'(tcp_h) <= a_q.l4_len) begin
              pay_present = 1'b1;
              pay_off     = a_q.l4_off + CW'(tcp_h);
              pay_len     = a_q.l4_len - CW'(tcp_h);
            end
          end
        end
        elp_pkg::PROTO_UDP: begin
          if (a_q.l4_len >= CW'(elp_pkg::UDP_HDR)) begin
            l4_kind = elp_pkg::L4_UDP;
            if (a_q.l4_len > CW'(elp_pkg::UDP_HDR)) begin
              pay_present = 1'b1;
              pay_off     = a_q.l4_off + CW'(elp_pkg::UDP_HDR);
              pay_len     = a_q.l4_len - CW'(elp_pkg::UDP_HDR);
            end
          end
        end
        elp_pkg::PROTO_ICMP, elp_pkg::PROTO_ICMPV6: begin
          if (a_q.l4_len >= CW'(ICMP_HDR_BYTES)) begin
            l4_kind = elp_pkg::L4_ICMP;
          end
        end
        default: begin
          l4_kind = elp_pkg::L4_NONE;
        end
      endcase
    end
  end

  // stage handshakes: each register advances when the one after it frees up
  assign out_adv = !out_v_q || result_o.ready;
  assign a_adv   = !a_v_q || out_adv;
  assign pop_o   = valid_i && a_adv;

  always_ff @(posedge clk_i) begin
    if (a_adv && valid_i) begin
      a_q <= a_d;
    end
    if (out_adv && a_v_q) begin
      result_o.status          <= a_q.status;
      result_o.ether_type      <= a_q.ether_type;
      result_o.l3_kind         <= a_q.l3_kind;
      result_o.ip_protocol     <= a_q.proto;
      result_o.l4_kind         <= l4_kind;
      result_o.l4_offset       <= (l4_kind == elp_pkg::L4_NONE) ? '0
                                  : elp_pkg::OFS_W'(a_q.l4_off);
      result_o.payload_present <= pay_present;
      result_o.payload_offset  <= elp_pkg::OFS_W'(pay_off);
      result_o.payload_length  <= elp_pkg::OFS_W'(pay_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_v_q <= valid_i;
      end
      if (out_adv) begin
        out_v_q <= a_v_q;
      end
    end
  end

  assign result_o.valid = out_v_q;

endmodule

>>> rtl/ethernet_ip_l4_header_parser.sv
// Ethernet / IPv4 / IPv6 / TCP / UDP / ICMP header parser.
// Input channel frame_i: one frame byte per beat, last_byte marks the final
// byte of a frame. Output channel result_o: one result beat per frame, with
// status, EtherType, layer-3 and layer-4 kinds, layer-4 offset and payload
// offset and length.
// Throughput: one byte per cycle while the queue is not full; frames of any
// length, one byte long included, follow back to back.
// The result of a frame passes from its last byte's beat through the queue,
// the layer-3 stage register and the output register to result_o.
// The front end and the back end meet at a two-entry queue. When the
// receiver stalls, the output register holds its beat, the back stages fill
// and the queue fills; frame_i.ready then drops until an entry drains.
// Frames longer than MAX_FRAME bytes stop the count and report oversize.
// Reset clears the byte counter, captured fields, queue and stage valids;
// no clearing pass is needed, so ready rises right after reset.
module ethernet_ip_l4_header_parser #(
  parameter int MAX_FRAME      = elp_pkg::MAX_FRAME_DEFAULT,
  parameter int ICMP_HDR_BYTES = elp_pkg::ICMP_HDR_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  elp_byte_if.sink    frame_i,
  elp_result_if.source result_o
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int QW = CW + $bits(elp_pkg::hdr_t);

  logic          beat;
  logic          push, q_full, q_valid, q_pop;
  logic [CW-1:0] f_len, b_len;
  elp_pkg::hdr_t f_hdr, b_hdr;

  assign frame_i.ready = !q_full;
  assign beat          = frame_i.valid && frame_i.ready;

  elp_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (frame_i.frame_byte),
    .last_i (frame_i.last_byte),
    .push_o (push),
    .len_o  (f_len),
    .hdr_o  (f_hdr)
  );

  elp_queue #(
    .W (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_len, f_hdr}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  ({b_len, b_hdr})
  );

  elp_back #(
    .MAX_FRAME      (MAX_FRAME),
    .ICMP_HDR_BYTES (ICMP_HDR_BYTES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .len_i    (b_len),
    .hdr_i    (b_hdr),
    .pop_o    (q_pop),
    .result_o (result_o)
  );

endmodule

>>> rtl/elp_checker.sv
// Port-level checks of the header parser, bound to the top level.
// Depends on elp_pkg and ethernet_ip_l4_header_parser_defines.svh.
`include "ethernet_ip_l4_header_parser_defines.svh"

module elp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [15:0] ether_type_i,
  input logic [1:0]  l3_kind_i,
  input logic [7:0]  ip_protocol_i,
  input logic [1:0]  l4_kind_i,
  input logic [11:0] l4_offset_i,
  input logic        payload_present_i,
  input logic [11:0] payload_offset_i,
  input logic [11:0] payload_length_i
);

  `ELP_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i)

  `ELP_ASSERT(a_result_held, out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(l4_offset_i) && $stable(payload_length_i))

  `ELP_ASSERT(a_bad_frame_bare, out_valid_i && (status_i != elp_pkg::ST_OK) |-> (ether_type_i == '0) && (l3_kind_i == '0) && (ip_protocol_i == '0) && (l4_kind_i == '0))

  `ELP_ASSERT(a_no_l4_no_payload, out_valid_i && (l4_kind_i == elp_pkg::L4_NONE) |-> (l4_offset_i == '0) && !payload_present_i)

  `ELP_ASSERT(a_payload_fields, out_valid_i && !payload_present_i |-> (payload_offset_i == '0) && (payload_length_i == '0))

endmodule

bind ethernet_ip_l4_header_parser elp_checker u_elp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .status_i          (result_o.status),
  .ether_type_i      (result_o.ether_type),
  .l3_kind_i         (result_o.l3_kind),
  .ip_protocol_i     (result_o.ip_protocol),
  .l4_kind_i         (result_o.l4_kind),
  .l4_offset_i       (result_o.l4_offset),
  .payload_present_i (result_o.payload_present),
  .payload_offset_i  (result_o.payload_offset),
  .payload_length_i  (result_o.payload_length)
);
